// ----- design/ats_pkg.sv -----
package ats_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int DEG_W    = 10;
  localparam int SEG_W    = 7;
  localparam int DIGIT_W  = 4;

  // Stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Sensor scaling: degrees over the full converter span
  localparam int CELSIUS_SPAN      = 330;
  localparam int FAHRENHEIT_SPAN   = 594;
  localparam int FAHRENHEIT_OFFSET = 32;

  // Fraction bits of the reciprocal constants; 2**28 exceeds sample * full scale
  localparam int RECIP_SHIFT = 28;

  // Largest value ever shown
  localparam int DEG_MAX = 626;

  // Segment pattern of the digit zero, bit0 = a .. bit6 = g
  localparam logic [SEG_W-1:0] SEG_ZERO = 7'b0111111;

  // Scaled value travelling from the scaling stage to the display stage
  typedef struct packed {
    logic             fahr;
    logic [DEG_W-1:0] deg;
  } ats_deg_t;

  // Decimal digit to seven-segment pattern
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 7'b0111111;
      4'd1:    p = 7'b0000110;
      4'd2:    p = 7'b1011011;
      4'd3:    p = 7'b1001111;
      4'd4:    p = 7'b1100110;
      4'd5:    p = 7'b1101101;
      4'd6:    p = 7'b1111101;
      4'd7:    p = 7'b0000111;
      4'd8:    p = 7'b1111111;
      4'd9:    p = 7'b1101111;
      default: p = 7'b0111111;
    endcase
    return p;
  endfunction

endpackage

// ----- design/ats_scale.sv -----
module ats_scale #(
  parameter int FULL_SCALE = 4095
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [ats_pkg::SAMPLE_W-1:0] up_sample,
  input  logic                        fahr,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output ats_pkg::ats_deg_t           dn_deg
);
  import ats_pkg::*;

  // Reciprocal constants, rounded up: (sample * C) >> RECIP_SHIFT is exact
  localparam longint unsigned CEL_K =
    ((longint'(CELSIUS_SPAN) << RECIP_SHIFT) + longint'(FULL_SCALE) - 1) / FULL_SCALE;
  localparam longint unsigned FAH_K =
    ((longint'(FAHRENHEIT_SPAN) << RECIP_SHIFT) + longint'(FULL_SCALE) - 1) / FULL_SCALE;
  localparam int COEF_W = $clog2(FAH_K + 1);
  localparam int PROD_W = (SAMPLE_W + COEF_W > RECIP_SHIFT + DEG_W) ?
                          (SAMPLE_W + COEF_W) : (RECIP_SHIFT + DEG_W);

  logic [SAMPLE_W-1:0] sat;
  logic [SAMPLE_W-1:0] smp_r;
  logic                fahr_a_r;
  logic                vld_a_r;
  logic                rdy_a;
  logic                rdy_b;
  logic [COEF_W-1:0]   coef;
  logic [PROD_W-1:0]   prod;
  ats_deg_t            deg_r;
  logic                vld_b_r;

  // Clamp samples above the configured full scale
  assign sat = (32'(up_sample) > 32'(FULL_SCALE)) ? SAMPLE_W'(FULL_SCALE) : up_sample;

  assign rdy_b    = !vld_b_r || dn_ready;
  assign rdy_a    = !vld_a_r || rdy_b;
  assign up_ready = rdy_a;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (rdy_a) begin
      vld_a_r <= up_valid;
    end
    if (rdy_a && up_valid) begin
      smp_r    <= sat;
      fahr_a_r <= fahr;
    end
  end

  // Scale by span / full scale as one multiply by the reciprocal
  assign coef = fahr_a_r ? COEF_W'(FAH_K) : COEF_W'(CEL_K);
  assign prod = PROD_W'(smp_r) * PROD_W'(coef);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (rdy_b) begin
      vld_b_r <= vld_a_r;
    end
    if (rdy_b && vld_a_r) begin
      deg_r.deg  <= prod[RECIP_SHIFT +: DEG_W];
      deg_r.fahr <= fahr_a_r;
    end
  end

  assign dn_valid = vld_b_r;
  assign dn_deg   = deg_r;

endmodule

// ----- design/ats_disp.sv -----
module ats_disp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  ats_pkg::ats_deg_t               up_deg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ats_pkg::OUT_TDATA_W-1:0] out_data
);
  import ats_pkg::*;

  logic [DEG_W-1:0]       val;
  logic [2:0]             hund;
  logic [6:0]             rem;
  logic [13:0]            tens_prod;
  logic [DIGIT_W-1:0]     tens;
  logic [DIGIT_W-1:0]     units;
  logic [OUT_TDATA_W-1:0] data_nxt;
  logic [OUT_TDATA_W-1:0] data_r;
  logic                   vld_r;
  logic                   rdy;

  // Add the Fahrenheit offset
  assign val = up_deg.deg + (up_deg.fahr ? DEG_W'(FAHRENHEIT_OFFSET) : DEG_W'(0));

  // Hundreds digit by comparison; the value stays below 700
  always_comb begin
    if      (val >= DEG_W'(600)) hund = 3'd6;
    else if (val >= DEG_W'(500)) hund = 3'd5;
    else if (val >= DEG_W'(400)) hund = 3'd4;
    else if (val >= DEG_W'(300)) hund = 3'd3;
    else if (val >= DEG_W'(200)) hund = 3'd2;
    else if (val >= DEG_W'(100)) hund = 3'd1;
    else                         hund = 3'd0;
  end

  // Tens as (rem * 103) >> 10, exact below 100
  assign rem       = 7'(val - DEG_W'(hund) * DEG_W'(100));
  assign tens_prod = 14'(rem) * 14'd103;
  assign tens      = DIGIT_W'(tens_prod >> 10);
  assign units     = DIGIT_W'(rem - 7'(tens) * 7'd10);

  assign data_nxt = {1'b0,
                     seg_of(DIGIT_W'(hund)),
                     seg_of(tens),
                     seg_of(units),
                     val};

  assign rdy      = !vld_r || out_ready;
  assign up_ready = rdy;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= up_valid;
    end
    if (rdy && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ----- design/adc_temperature_to_seven_segment_unit.sv -----
// Converter sample to three-digit seven-segment display.
//
// Input stream (in_*): one 12-bit sample per transfer in in_tdata[11:0].
// Output stream (out_*): one result per sample, holding the whole-degree value
// and the segment patterns of its units, tens and hundreds digits.
// Configuration: cfg_wr_en high for one clock writes cfg_wr_data into the
// unit select (0 Celsius, 1 Fahrenheit); write only while the block is empty.
//
// Three register stages: input register, scaling multiply, result register.
// One sample can be accepted every cycle while out_tready is high; the single
// reciprocal multiply sets the stage timing. Samples above ADC_FULL_SCALE are
// clamped to it.
//
// Reset empties all stages and selects Celsius. If the receiver holds
// out_tready low, results stay in place and in_tready falls once all three
// stages are full; nothing is dropped.
module adc_temperature_to_seven_segment_unit #(
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ats_pkg::IN_TDATA_W-1:0]  in_tdata,   // [11:0] adc_sample
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [9:0] shown_value, [16:10] seg_units, [23:17] seg_tens, [30:24] seg_hundreds
  output logic [ats_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data
);
  import ats_pkg::*;

  logic     fahr_r;
  logic     mid_valid;
  logic     mid_ready;
  ats_deg_t mid_deg;

  // Unit select register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fahr_r <= 1'b0;
    end else if (cfg_wr_en) begin
      fahr_r <= cfg_wr_data;
    end
  end

  ats_scale #(
    .FULL_SCALE (ADC_FULL_SCALE)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .up_sample (in_tdata[SAMPLE_W-1:0]),
    .fahr      (fahr_r),
    .dn_valid  (mid_valid),
    .dn_ready  (mid_ready),
    .dn_deg    (mid_deg)
  );

  ats_disp u_disp (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (mid_valid),
    .up_ready  (mid_ready),
    .up_deg    (mid_deg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ----- design/ats_checker.sv -----
module ats_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ats_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ats_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Input back-pressure only when the output is stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

  // Shown value stays in range
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DEG_W-1:0] <= DEG_W'(DEG_MAX))
    else $error("shown value out of range");

  // Values below one hundred show a zero hundreds digit
  a_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[DEG_W-1:0] < DEG_W'(100)) |->
      out_tdata[30:24] == SEG_ZERO)
    else $error("hundreds digit wrong for small value");

endmodule

bind adc_temperature_to_seven_segment_unit ats_checker u_ats_checker (.*);
